FILE: rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types and constants for the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int FRAME_W    = 12;
	localparam int COUNT_W    = 13;
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;

	localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

	// register indexes (byte address / 4)
	localparam logic REG_FRAME_COUNT = 1'b0;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [FRAME_W-1:0] entry_frame;
		logic               kernel_page;
		logic               is_writable;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] new_frame;
		logic               present;
		logic               writable;
		logic               user_mode;
		logic               entry_changed;
		logic               no_free;
	} rsp_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
	} cfg_t;

endpackage

FILE: rtl/pfba_ram.sv
// ----------------------------------------------------------------------------
// pfba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]                              wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/pfba_regs.sv
// ----------------------------------------------------------------------------
// pfba_regs
// APB configuration register: frame count.
// ----------------------------------------------------------------------------
module pfba_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pfba_pkg::PADDR_W-1:0]       paddr,
	input  logic [pfba_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pfba_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	output pfba_pkg::cfg_t                     cfg
);
	import pfba_pkg::*;

	logic [COUNT_W-1:0] frame_count_q;
	logic               reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1] == REG_FRAME_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			frame_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata          = reg_hit ? {{(APB_DATA_W-COUNT_W){1'b0}}, frame_count_q}
	                                 : '0;
	assign cfg.frame_count = frame_count_q;

endmodule

FILE: rtl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit page frame allocator over a bitmap kept in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): one alloc or free transaction per
//   page entry. rsp channel (rsp_valid/rsp_stall/rsp): exactly one response
//   transaction per request, in order. APB port: frame_count at byte 0.
// Path from acceptance to the response register (one request in flight at
// a time):
//   alloc with a frame already present, free without a frame: deliver state.
//   alloc scan: one bitmap word read per cycle, from word 0 up to the first
//     word with a clear bit; with no clear bit all W words are read,
//     W = min(frame_count, MAX_FRAMES) / WORD_BITS (128 at the defaults).
//   free: word index and bit taken straight from entry_frame, one read and
//     one write of the RAM (read state, write state, then deliver).
//   The next request is taken as soon as the previous response sits in the
//   output register, even if the receiver has not taken it yet.
// Reset: a clearing pass writes zero to every bitmap word, one word per
//   cycle, WORD_COUNT words (128 at the default parameters); req_stall stays
//   high meanwhile. Configuration writes are accepted at any time.
// Receiver stall: the response holds in the output register; a finished
//   result behind it waits in the deliver state.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator #(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  pfba_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output pfba_pkg::rsp_t                     rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pfba_pkg::PADDR_W-1:0]       paddr,
	input  logic [pfba_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pfba_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import pfba_pkg::*;

	localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BW         = $clog2(WORD_BITS);
	localparam int BASE_W     = $clog2(MAX_FRAMES + WORD_BITS) + 1;
	localparam int CW         = (BASE_W > COUNT_W) ? BASE_W : COUNT_W;

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_FREE_RD = 7'b0001000,
		ST_FREE_WR = 7'b0010000,
		ST_DELIVER = 7'b0100000,
		ST_SPARE   = 7'b1000000
	} state_t;

	state_t              state_q;
	cfg_t                cfg;
	logic [AW:0]         w_q;
	logic [BW-1:0]       rem_q;
	logic [CW-1:0]       issue_base_q;
	logic                chk_valid_q;
	logic [CW-1:0]       chk_base_q;
	logic [AW-1:0]       chk_addr_q;
	req_t                req_q;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [WORD_BITS-1:0] ram_wr_data;
	logic [AW-1:0]        ram_rd_addr;
	logic [WORD_BITS-1:0] rd_word;

	logic [CW-1:0]        count_ext;
	logic [CW-1:0]        limit;
	logic [CW-1:0]        issue_next;
	logic                 issue_ok;
	logic                 found;
	logic [BW-1:0]        zero_idx;
	logic [WORD_BITS-1:0] set_mask;
	logic [WORD_BITS-1:0] clr_mask;
	logic [CW-1:0]        found_frame;
	logic                 req_acc;
	logic                 slot_free;
	logic                 entry_in_store;
	rsp_t                 accept_res;
	rsp_t                 scan_res;

	pfba_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (rd_word)
	);

	// scan limit: whole words below min(frame_count, MAX_FRAMES)
	assign count_ext  = {{(CW-COUNT_W){1'b0}}, cfg.frame_count};
	assign limit      = (count_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : count_ext;
	assign issue_next = issue_base_q + CW'(WORD_BITS);
	assign issue_ok   = (issue_next <= limit);
	assign found      = chk_valid_q && !(&rd_word);

	// lowest clear bit of the word under check
	always_comb begin
		zero_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!rd_word[i]) begin
				zero_idx = BW'(i);
			end
		end
	end

	assign set_mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << zero_idx;
	assign clr_mask    = ~({{(WORD_BITS-1){1'b0}}, 1'b1} << rem_q);
	assign found_frame = chk_base_q + {{(CW-BW){1'b0}}, zero_idx};

	assign req_stall      = (state_q != ST_IDLE);
	assign req_acc        = req_valid && !req_stall;
	assign slot_free      = !rsp_valid_q || !rsp_stall;
	assign entry_in_store = ({{(CW-FRAME_W){1'b0}}, req.entry_frame} < CW'(MAX_FRAMES));

	// response fields known at acceptance
	always_comb begin
		accept_res = '0;
		if (req.kind == KIND_ALLOC) begin
			accept_res.new_frame = req.entry_frame;
		end else if (req.entry_frame != '0) begin
			accept_res.entry_changed = 1'b1;
		end
	end

	// response fields at the end of a scan
	always_comb begin
		scan_res = '0;
		if (found) begin
			scan_res.new_frame     = found_frame[FRAME_W-1:0];
			scan_res.present       = 1'b1;
			scan_res.writable      = req_q.is_writable;
			scan_res.user_mode     = !req_q.kernel_page;
			scan_res.entry_changed = 1'b1;
		end else begin
			scan_res.no_free = 1'b1;
		end
	end

	// RAM port control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = w_q[AW-1:0];
		ram_wr_data = '0;
		ram_rd_addr = w_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en = 1'b1;
			end
			ST_SCAN: begin
				if (found) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = chk_addr_q;
					ram_wr_data = rd_word | set_mask;
				end
			end
			ST_FREE_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = rd_word & clr_mask;
			end
			ST_IDLE, ST_FREE_RD, ST_DELIVER, ST_SPARE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DELIVER) && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			w_q         <= '0;
			chk_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					w_q <= w_q + 1'b1;
					if (w_q == (AW+1)'(WORD_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						chk_valid_q <= 1'b0;
						if (req.kind == KIND_ALLOC) begin
							w_q <= '0;
							if (req.entry_frame != '0) begin
								state_q <= ST_DELIVER;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							w_q <= (AW+1)'(req.entry_frame >> BW);
							if ((req.entry_frame != '0) && entry_in_store) begin
								state_q <= ST_FREE_RD;
							end else begin
								state_q <= ST_DELIVER;
							end
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						state_q <= ST_DELIVER;
					end else if (issue_ok) begin
						chk_valid_q <= 1'b1;
						w_q         <= w_q + 1'b1;
					end else begin
						state_q <= ST_DELIVER;
					end
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_WR;
				end
				ST_FREE_WR: begin
					state_q <= ST_DELIVER;
				end
				ST_DELIVER: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SPARE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					req_q        <= req;
					rem_q        <= req.entry_frame[BW-1:0];
					issue_base_q <= '0;
					res_q        <= accept_res;
				end
			end
			ST_SCAN: begin
				if (found) begin
					res_q <= scan_res;
				end else if (issue_ok) begin
					chk_addr_q   <= w_q[AW-1:0];
					chk_base_q   <= issue_base_q;
					issue_base_q <= issue_next;
				end else begin
					res_q <= scan_res;
				end
			end
			ST_DELIVER: begin
				if (slot_free) begin
					rsp_q <= res_q;
				end
			end
			ST_CLEAR, ST_FREE_RD, ST_FREE_WR, ST_SPARE: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/pfba_checker.sv
// ----------------------------------------------------------------------------
// pfba_checker
// Port-level assertions for the page frame bitmap allocator.
// ----------------------------------------------------------------------------
module pfba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input pfba_pkg::rsp_t rsp
);
	import pfba_pkg::*;

	// a stalled response transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("response changed while stalled");

	// one request in flight: the block stalls right after taking a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous one still in work");

	// a fresh response only appears while the request side is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a request in work");

	// a granted frame always writes back the entry and never flags exhaustion
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.present) |-> (rsp.entry_changed && !rsp.no_free))
		else $error("inconsistent alloc response");

	// exhaustion leaves the entry alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.no_free) |->
			(!rsp.entry_changed && !rsp.present && (rsp.new_frame == '0)))
		else $error("no_free response modifies entry");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
